// File: sv/dci_pkg.sv
// Package for the double circle inversion pipeline.
// Holds widths, register indexes and reset values. No dependencies.
package dci_pkg;
  localparam int CW = 32;
  localparam int RW = 31;
  localparam int FB = 16;
  localparam int DW = CW + 1;          // offset magnitude
  localparam int SW = 2 * DW + 1;      // squared distance
  localparam int NW = RW + FB + DW;    // dividend
  localparam int QW = NW;              // quotient
  localparam int IW = 3;

  localparam logic [IW-1:0] REG_C1X = 3'd0;
  localparam logic [IW-1:0] REG_C1Y = 3'd1;
  localparam logic [IW-1:0] REG_R1 = 3'd2;
  localparam logic [IW-1:0] REG_C2X = 3'd3;
  localparam logic [IW-1:0] REG_C2Y = 3'd4;
  localparam logic [IW-1:0] REG_R2 = 3'd5;

  localparam logic [CW-1:0] RST_C1X = 32'sd50077;
  localparam logic [CW-1:0] RST_C1Y = -32'sd77991;
  localparam logic [RW-1:0] RST_R1 = 31'd65536;
  localparam logic [CW-1:0] RST_C2X = 32'sd50077;
  localparam logic [CW-1:0] RST_C2Y = 32'sd77991;
  localparam logic [RW-1:0] RST_R2 = 31'd65536;

  localparam logic signed [CW+1:0] MAXV = (34'sd1 <<< (CW - 1)) - 34'sd1;
  localparam logic signed [CW+1:0] MINV = -(34'sd1 <<< (CW - 1));

  // saturate a wider signed sum to the coordinate range
  function automatic logic [CW:0] sat(input logic signed [CW+1:0] v);
    logic [CW:0] r;
    if (v > MAXV) r = {1'b1, MAXV[CW-1:0]};
    else if (v < MINV) r = {1'b1, MINV[CW-1:0]};
    else r = {1'b0, v[CW-1:0]};
    return r;
  endfunction
endpackage

// File: sv/double_circle_inversion.sv
// Double circle inversion with accumulator, top level.
// Throughput: one transaction per cycle; the whole pipeline stalls
// when the output register is full and not taken.
// Reset (rst_n, synchronous): pipeline valid bits cleared, registers
// return to their reset values. Uses dci_pkg and dci_invert.
module double_circle_inversion (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [127:0]  in_tdata,   // point_x, point_y, acc_in_x, acc_in_y
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [63:0]   out_tdata,  // out_x, out_y
  output logic          out_tuser,  // overflow
  input  logic          cfg_we,
  input  logic [dci_pkg::IW-1:0] cfg_index,
  input  logic [31:0]   cfg_wdata
);
  localparam int CW = dci_pkg::CW;
  logic [CW-1:0] c1x_r, c1y_r, c2x_r, c2y_r;
  logic [dci_pkg::RW-1:0] r1_r, r2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1x_r <= dci_pkg::RST_C1X;
      c1y_r <= dci_pkg::RST_C1Y;
      r1_r <= dci_pkg::RST_R1;
      c2x_r <= dci_pkg::RST_C2X;
      c2y_r <= dci_pkg::RST_C2Y;
      r2_r <= dci_pkg::RST_R2;
    end else if (cfg_we) begin
      case (cfg_index)
        dci_pkg::REG_C1X: c1x_r <= cfg_wdata;
        dci_pkg::REG_C1Y: c1y_r <= cfg_wdata;
        dci_pkg::REG_R1: r1_r <= cfg_wdata[dci_pkg::RW-1:0];
        dci_pkg::REG_C2X: c2x_r <= cfg_wdata;
        dci_pkg::REG_C2Y: c2y_r <= cfg_wdata;
        dci_pkg::REG_R2: r2_r <= cfg_wdata[dci_pkg::RW-1:0];
        default: ;
      endcase
    end
  end

  logic en;
  assign en = !out_tvalid || out_tready;
  assign in_tready = en;

  logic          v1, f1, v2, f2;
  logic [CW-1:0] x1, y1, ax1, ay1, x2, y2, ax2, ay2;

  dci_invert u_inv1 (
    .clk(clk), .rst_n(rst_n), .en(en), .vin(in_tvalid),
    .px(in_tdata[31:0]), .py(in_tdata[63:32]),
    .ax(in_tdata[95:64]), .ay(in_tdata[127:96]), .fin(1'b0),
    .cx(c1x_r), .cy(c1y_r), .r2(r1_r),
    .vout(v1), .qx(x1), .qy(y1), .axo(ax1), .ayo(ay1), .fout(f1)
  );
  dci_invert u_inv2 (
    .clk(clk), .rst_n(rst_n), .en(en), .vin(v1),
    .px(x1), .py(y1), .ax(ax1), .ay(ay1), .fin(f1),
    .cx(c2x_r), .cy(c2y_r), .r2(r2_r),
    .vout(v2), .qx(x2), .qy(y2), .axo(ax2), .ayo(ay2), .fout(f2)
  );

  logic [CW:0] sx, sy;
  assign sx = dci_pkg::sat($signed({{2{ax2[CW-1]}}, ax2}) + $signed({{2{x2[CW-1]}}, x2}));
  assign sy = dci_pkg::sat($signed({{2{ay2[CW-1]}}, ay2}) + $signed({{2{y2[CW-1]}}, y2}));

  always_ff @(posedge clk) begin
    if (!rst_n) out_tvalid <= 1'b0;
    else if (en) out_tvalid <= v2;
    if (en) begin
      out_tdata <= {sy[CW-1:0], sx[CW-1:0]};
      out_tuser <= f2 | sx[CW] | sy[CW];
    end
  end

`ifndef NO_ASSERTIONS
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid) else $error("output lost");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready)) else $error("ready mismatch");
  a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we && cfg_index == dci_pkg::REG_C1X |=> c1x_r == $past(cfg_wdata))
    else $error("cfg write lost");
`endif
endmodule

// File: sv/dci_invert.sv
// One circle inversion, pipelined. Restoring division one quotient bit
// per stage. Uses dci_pkg.
module dci_invert (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 vin,
  input  logic [dci_pkg::CW-1:0] px,
  input  logic [dci_pkg::CW-1:0] py,
  input  logic [dci_pkg::CW-1:0] ax,
  input  logic [dci_pkg::CW-1:0] ay,
  input  logic                 fin,
  input  logic [dci_pkg::CW-1:0] cx,
  input  logic [dci_pkg::CW-1:0] cy,
  input  logic [dci_pkg::RW-1:0] r2,
  output logic                 vout,
  output logic [dci_pkg::CW-1:0] qx,
  output logic [dci_pkg::CW-1:0] qy,
  output logic [dci_pkg::CW-1:0] axo,
  output logic [dci_pkg::CW-1:0] ayo,
  output logic                 fout
);
  localparam int CW = dci_pkg::CW;
  localparam int DW = dci_pkg::DW;
  localparam int SW = dci_pkg::SW;
  localparam int NW = dci_pkg::NW;
  localparam int PW = dci_pkg::RW + DW;

  typedef struct packed {
    logic [CW-1:0] ax;
    logic [CW-1:0] ay;
    logic [CW-1:0] cx;
    logic [CW-1:0] cy;
    logic          nx;
    logic          ny;
    logic          zero;
    logic          f;
  } side_t;

  // stage 1: differences
  logic          v1_r;
  side_t         s1_r;
  logic [DW-1:0] dx1_r, dy1_r;
  logic [dci_pkg::RW-1:0] r1_r;
  logic signed [CW:0] ddx, ddy;
  assign ddx = $signed({px[CW-1], px}) - $signed({cx[CW-1], cx});
  assign ddy = $signed({py[CW-1], py}) - $signed({cy[CW-1], cy});

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (en) v1_r <= vin;
    if (en) begin
      s1_r <= '{ax: ax, ay: ay, cx: cx, cy: cy, nx: ddx[CW], ny: ddy[CW],
                zero: 1'b0, f: fin};
      dx1_r <= ddx[CW] ? DW'(-ddx) : DW'(ddx);
      dy1_r <= ddy[CW] ? DW'(-ddy) : DW'(ddy);
      r1_r <= r2;
    end
  end

  // stage 2: squares and scale products
  logic          v2_r;
  side_t         s2_r;
  logic [2*DW-1:0] sqx_r, sqy_r;
  logic [NW-1:0] nx2_r, ny2_r;
  logic [PW-1:0] px2, py2;
  assign px2 = PW'(r1_r) * PW'(dx1_r);
  assign py2 = PW'(r1_r) * PW'(dy1_r);
  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (en) v2_r <= v1_r;
    if (en) begin
      s2_r <= s1_r;
      sqx_r <= dx1_r * dx1_r;
      sqy_r <= dy1_r * dy1_r;
      nx2_r <= {px2, {dci_pkg::FB{1'b0}}};
      ny2_r <= {py2, {dci_pkg::FB{1'b0}}};
    end
  end

  // stage 3: squared distance and zero flag
  logic          v3_r;
  side_t         s3_r;
  side_t         s3_nxt;
  logic [SW-1:0] d3_r;
  logic [NW-1:0] nx3_r, ny3_r;
  logic [SW-1:0] dsum;
  assign dsum = SW'(sqx_r) + SW'(sqy_r);
  always_comb begin
    s3_nxt = s2_r;
    s3_nxt.zero = (dsum == '0);
  end
  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (en) v3_r <= v2_r;
    if (en) begin
      s3_r <= s3_nxt;
      d3_r <= dsum;
      nx3_r <= nx2_r;
      ny3_r <= ny2_r;
    end
  end

  // division stages: one bit per stage, msb first
  logic [NW:0]   dv;
  side_t         ds [NW+1];
  logic [SW-1:0] dd [NW+1];
  logic [NW-1:0] rx [NW+1], ry [NW+1], kx [NW+1], ky [NW+1];
  logic [NW-1:0] qxs [NW+1], qys [NW+1];
  assign dv[0] = v3_r;
  assign ds[0] = s3_r;
  assign dd[0] = d3_r;
  assign rx[0] = '0;
  assign ry[0] = '0;
  assign kx[0] = nx3_r;
  assign ky[0] = ny3_r;
  assign qxs[0] = '0;
  assign qys[0] = '0;

  for (genvar i = 0; i < NW; i++) begin : g_div
    logic          v_r;
    side_t         s_r;
    logic [SW-1:0] d_r;
    logic [NW-1:0] rx_r, ry_r, kx_r, ky_r, qx_r, qy_r;
    logic [NW:0]   tx, ty;
    logic          gx, gy;
    assign tx = {rx[i], kx[i][NW-1]};
    assign ty = {ry[i], ky[i][NW-1]};
    assign gx = ({{(SW > NW + 1 ? SW - NW - 1 : 0){1'b0}}, tx} >= (NW + 1 > SW ?
                 (NW+1)'(dd[i]) : dd[i]));
    assign gy = ({{(SW > NW + 1 ? SW - NW - 1 : 0){1'b0}}, ty} >= (NW + 1 > SW ?
                 (NW+1)'(dd[i]) : dd[i]));
    always_ff @(posedge clk) begin
      if (!rst_n) v_r <= 1'b0;
      else if (en) v_r <= dv[i];
      if (en) begin
        s_r <= ds[i];
        d_r <= dd[i];
        rx_r <= gx ? NW'(tx - (NW+1)'(dd[i])) : NW'(tx);
        ry_r <= gy ? NW'(ty - (NW+1)'(dd[i])) : NW'(ty);
        kx_r <= {kx[i][NW-2:0], 1'b0};
        ky_r <= {ky[i][NW-2:0], 1'b0};
        qx_r <= {qxs[i][NW-2:0], gx};
        qy_r <= {qys[i][NW-2:0], gy};
      end
    end
    assign dv[i+1] = v_r;
    assign ds[i+1] = s_r;
    assign dd[i+1] = d_r;
    assign rx[i+1] = rx_r;
    assign ry[i+1] = ry_r;
    assign kx[i+1] = kx_r;
    assign ky[i+1] = ky_r;
    assign qxs[i+1] = qx_r;
    assign qys[i+1] = qy_r;
  end

  // offset clamp, zero distance
  localparam logic [NW-1:0] MAXM = NW'(dci_pkg::MAXV);
  logic          vc_r;
  side_t         sc_r;
  side_t         sc_nxt;
  logic signed [CW+1:0] ox_r, oy_r;
  logic [NW-1:0] mx, my;
  logic          ofx, ofy;
  side_t         sf;
  assign sf = ds[NW];
  always_comb begin
    mx = qxs[NW];
    my = qys[NW];
    ofx = 1'b0;
    ofy = 1'b0;
    if (sf.zero) begin
      mx = MAXM;
      my = MAXM;
    end else begin
      if (mx > MAXM + NW'(sf.nx)) begin
        mx = MAXM + NW'(sf.nx);
        ofx = 1'b1;
      end
      if (my > MAXM + NW'(sf.ny)) begin
        my = MAXM + NW'(sf.ny);
        ofy = 1'b1;
      end
    end
    sc_nxt = sf;
    sc_nxt.f = sf.f | sf.zero | ofx | ofy;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) vc_r <= 1'b0;
    else if (en) vc_r <= dv[NW];
    if (en) begin
      sc_r <= sc_nxt;
      ox_r <= (sf.nx && !sf.zero) ? -$signed({2'b0, mx[CW-1:0]}) :
              $signed({2'b0, mx[CW-1:0]});
      oy_r <= (sf.ny && !sf.zero) ? -$signed({2'b0, my[CW-1:0]}) :
              $signed({2'b0, my[CW-1:0]});
    end
  end

  // center plus offset
  logic [CW:0] rxs, rys;
  assign rxs = dci_pkg::sat($signed({{2{sc_r.cx[CW-1]}}, sc_r.cx}) + ox_r);
  assign rys = dci_pkg::sat($signed({{2{sc_r.cy[CW-1]}}, sc_r.cy}) + oy_r);
  always_ff @(posedge clk) begin
    if (!rst_n) vout <= 1'b0;
    else if (en) vout <= vc_r;
    if (en) begin
      qx <= rxs[CW-1:0];
      qy <= rys[CW-1:0];
      axo <= sc_r.ax;
      ayo <= sc_r.ay;
      fout <= sc_r.f | rxs[CW] | rys[CW];
    end
  end
endmodule
